### src/wodo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel odometry package
// Shared constants, the sequencer state type and a saturation helper.
// ----------------------------------------------------------------------------
package wodo_pkg;

    localparam int ENCODER_BITS_DEF = 12;
    localparam int MPC_W            = 24;
    localparam logic [MPC_W-1:0] MPC_RESET = 24'd8192;
    localparam int ACC_W            = 48;
    localparam int OUT_W            = 32;
    localparam int MUL_AW           = 32;
    localparam int MUL_BW           = 24;
    localparam logic [MUL_BW-1:0] K085_Q16 = 24'd55706;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DIST,
        ST_ACC,
        ST_MUL_VEL,
        ST_SUM,
        ST_VEL,
        ST_ACCEL,
        ST_JERK,
        ST_OUT
    } state_t;

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [41:0] x);
        logic signed [41:0] hi_lim;
        logic signed [41:0] lo_lim;
        hi_lim = 42'sd2147483647;
        lo_lim = -42'sd2147483648;
        if (x > hi_lim) begin
            return 32'sh7FFF_FFFF;
        end else if (x < lo_lim) begin
            return 32'sh8000_0000;
        end
        return x[OUT_W-1:0];
    endfunction

endpackage

### src/wodo_wrap_avg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel odometry wrap-corrected average
// Forms the wrap-corrected count delta of each wheel and their average,
// truncated towards zero. A zero stored reading gives no motion.
// ----------------------------------------------------------------------------
module wodo_wrap_avg #(
    parameter int ENCODER_BITS = wodo_pkg::ENCODER_BITS_DEF
) (
    input  logic [ENCODER_BITS-1:0]      cur_left,
    input  logic [ENCODER_BITS-1:0]      cur_right,
    input  logic [ENCODER_BITS-1:0]      last_left,
    input  logic [ENCODER_BITS-1:0]      last_right,
    output logic signed [ENCODER_BITS:0] avg
);

    localparam int DW = ENCODER_BITS + 2;
    localparam logic [ENCODER_BITS-1:0] LO_U = ENCODER_BITS'((1 << ENCODER_BITS) / 4);
    localparam logic [ENCODER_BITS-1:0] HI_U = ENCODER_BITS'(3 * ((1 << ENCODER_BITS) / 4));
    localparam logic signed [DW-1:0] FULL_S = DW'(1 << ENCODER_BITS);

    function automatic logic signed [DW-1:0] wrap_delta(
        input logic [ENCODER_BITS-1:0] cur,
        input logic [ENCODER_BITS-1:0] prev
    );
        logic signed [DW-1:0] c;
        logic signed [DW-1:0] p;
        c = {2'b00, cur};
        p = {2'b00, prev};
        if (cur < LO_U && prev > HI_U) begin
            return c + FULL_S - p;
        end else if (cur > HI_U && prev < LO_U) begin
            return c - FULL_S - p;
        end
        return c - p;
    endfunction

    logic signed [DW-1:0] sum;
    logic signed [DW-1:0] rounded;

    always_comb begin
        sum     = wrap_delta(cur_left, last_left) + wrap_delta(cur_right, last_right);
        rounded = sum + {{(DW-1){1'b0}}, sum[DW-1]};
        if (last_left == '0 || last_right == '0) begin
            avg = '0;
        end else begin
            avg = rounded[DW-1:1];
        end
    end

endmodule

### src/wodo_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel odometry serial multiplier
// Signed by unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module wodo_serial_mul #(
    parameter int AW = wodo_pkg::MUL_AW,
    parameter int BW = wodo_pkg::MUL_BW
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [AW-1:0] a_in,
    input  logic [BW-1:0]        b_in,
    output logic                 done,
    output logic [AW+BW-1:0]     product
);

    localparam int CW = (BW > 1) ? $clog2(BW) : 1;
    localparam logic [CW-1:0] LAST = CW'(BW - 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic signed [AW-1:0] a_reg, a_next;
    logic [BW-1:0] b_reg, b_next;
    logic signed [AW:0] hi_reg, hi_next;
    logic [BW-1:0] lo_reg, lo_next;
    logic signed [AW:0] addend;
    logic signed [AW:0] sum;

    always_comb begin
        addend    = b_reg[0] ? {a_reg[AW-1], a_reg} : '0;
        sum       = hi_reg + addend;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a_in;
            b_next    = b_in;
            hi_next   = '0;
            lo_next   = '0;
        end else if (busy_reg) begin
            hi_next  = {sum[AW], sum[AW:1]};
            lo_next  = {sum[0], lo_reg[BW-1:1]};
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg[AW-1:0], lo_reg};

endmodule

### src/wheel_odometry_velocity_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel odometry velocity estimator
// Accumulates wheel distance and reports filtered velocity, acceleration and
// jerk at the end of each update window.
// ----------------------------------------------------------------------------
// Each input transfer carries the left and right encoder readings in
// s_axis_tdata and the window-end flag in s_axis_tlast. Transfers without
// tlast only update the stored readings and the distance accumulator and
// produce nothing on the master side. A transfer with tlast produces one
// output transfer carrying velocity, acceleration and jerk in signed Q15.16.
// An ordinary item occupies the block while the serial multiplier scales the
// count average by the meters-per-count register. A window-end item also
// runs the same multiplier a second pass for the velocity filter and may
// wait for the output register. s_axis_tready is high only while the block
// is idle. Reset clears the stored readings, the accumulator and the filter
// state, and sets meters-per-count to 8192. If the receiver stalls, the
// finished result waits in the output register and the block carries on
// accepting items; a second result waits until the first transfer completes.
// cfg_wr_en writes meters-per-count; the user must use it only while the
// block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module wheel_odometry_velocity_estimator #(
    parameter int ENCODER_BITS = wodo_pkg::ENCODER_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [wodo_pkg::MPC_W-1:0]            cfg_wr_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // left_count, right_count, zero padding
    input  logic [((2*ENCODER_BITS+7)/8)*8-1:0]   s_axis_tdata,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // velocity_q16, acceleration_q16, jerk_q16
    output logic [3*wodo_pkg::OUT_W-1:0]          m_axis_tdata
);

    localparam int EB    = ENCODER_BITS;
    localparam int AW    = wodo_pkg::MUL_AW;
    localparam int BW    = wodo_pkg::MUL_BW;
    localparam int ACC_W = wodo_pkg::ACC_W;
    localparam int OW    = wodo_pkg::OUT_W;

    wodo_pkg::state_t state_reg, state_next;

    logic [EB-1:0]          last_left_reg, last_left_next;
    logic [EB-1:0]          last_right_reg, last_right_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [OW-1:0]   speed_reg, speed_next;
    logic signed [OW-1:0]   accel_reg, accel_next;
    logic [wodo_pkg::MPC_W-1:0] mpc_reg;
    logic                   wend_reg, wend_next;
    logic signed [57:0]     q_reg, q_next;
    logic signed [OW-1:0]   vnew_reg, vnew_next;
    logic signed [OW-1:0]   anew_reg, anew_next;
    logic signed [OW-1:0]   jerk_reg, jerk_next;
    logic [3*OW-1:0]        out_data_reg, out_data_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    logic [EB-1:0]          in_left;
    logic [EB-1:0]          in_right;
    logic signed [EB:0]     avg;
    logic                   in_fire;
    logic                   out_free;

    logic                   mul_start;
    logic signed [AW-1:0]   mul_a;
    logic [BW-1:0]          mul_b;
    logic                   mul_done;
    logic [AW+BW-1:0]       mul_prod;

    logic signed [48:0]     acc_sum;
    logic signed [57:0]     p58;
    logic signed [57:0]     a58;
    logic signed [32:0]     diff_v;
    logic signed [32:0]     diff_a;
    logic signed [41:0]     dx_v;
    logic signed [41:0]     dx_a;

    assign in_left  = s_axis_tdata[EB-1:0];
    assign in_right = s_axis_tdata[2*EB-1:EB];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_tvalid_reg || m_axis_tready;

    wodo_wrap_avg #(
        .ENCODER_BITS(ENCODER_BITS)
    ) u_wrap_avg (
        .cur_left   (in_left),
        .cur_right  (in_right),
        .last_left  (last_left_reg),
        .last_right (last_right_reg),
        .avg        (avg)
    );

    wodo_serial_mul #(
        .AW(AW),
        .BW(BW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_comb begin
        state_next      = state_reg;
        last_left_next  = last_left_reg;
        last_right_next = last_right_reg;
        acc_next        = acc_reg;
        speed_next      = speed_reg;
        accel_next      = accel_reg;
        wend_next       = wend_reg;
        q_next          = q_reg;
        vnew_next       = vnew_reg;
        anew_next       = anew_reg;
        jerk_next       = jerk_reg;
        out_data_next   = out_data_reg;
        m_tvalid_next   = m_tvalid_reg && !m_axis_tready;
        s_axis_tready   = 1'b0;
        mul_start       = 1'b0;
        mul_a           = {{(AW-EB-1){avg[EB]}}, avg};
        mul_b           = mpc_reg;

        acc_sum = {acc_reg[ACC_W-1], acc_reg} + $signed(mul_prod[48:0]);
        p58     = {{9{mul_prod[48]}}, mul_prod[48:0]};
        a58     = {{10{acc_reg[ACC_W-1]}}, acc_reg};
        diff_v  = {vnew_reg[OW-1], vnew_reg} - {speed_reg[OW-1], speed_reg};
        diff_a  = {anew_reg[OW-1], anew_reg} - {accel_reg[OW-1], accel_reg};
        dx_v    = {{9{diff_v[32]}}, diff_v};
        dx_a    = {{9{diff_a[32]}}, diff_a};

        unique case (state_reg)
            wodo_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    mul_start       = 1'b1;
                    last_left_next  = in_left;
                    last_right_next = in_right;
                    wend_next       = s_axis_tlast;
                    state_next      = wodo_pkg::ST_MUL_DIST;
                end
            end
            wodo_pkg::ST_MUL_DIST: begin
                if (mul_done) begin
                    state_next = wodo_pkg::ST_ACC;
                end
            end
            wodo_pkg::ST_ACC: begin
                if (acc_sum[48] != acc_sum[47]) begin
                    acc_next = acc_sum[48] ? {1'b1, {(ACC_W-1){1'b0}}}
                                           : {1'b0, {(ACC_W-1){1'b1}}};
                end else begin
                    acc_next = acc_sum[ACC_W-1:0];
                end
                if (wend_reg) begin
                    mul_start  = 1'b1;
                    mul_a      = speed_reg;
                    mul_b      = wodo_pkg::K085_Q16;
                    state_next = wodo_pkg::ST_MUL_VEL;
                end else begin
                    state_next = wodo_pkg::ST_IDLE;
                end
            end
            wodo_pkg::ST_MUL_VEL: begin
                if (mul_done) begin
                    state_next = wodo_pkg::ST_SUM;
                end
            end
            wodo_pkg::ST_SUM: begin
                q_next     = p58 + (a58 <<< 8) + (a58 <<< 7) + 58'sd32768;
                state_next = wodo_pkg::ST_VEL;
            end
            wodo_pkg::ST_VEL: begin
                vnew_next  = wodo_pkg::sat32(q_reg[57:16]);
                state_next = wodo_pkg::ST_ACCEL;
            end
            wodo_pkg::ST_ACCEL: begin
                anew_next  = wodo_pkg::sat32((dx_v <<< 3) + (dx_v <<< 1));
                state_next = wodo_pkg::ST_JERK;
            end
            wodo_pkg::ST_JERK: begin
                jerk_next  = wodo_pkg::sat32((dx_a <<< 3) + (dx_a <<< 1));
                state_next = wodo_pkg::ST_OUT;
            end
            wodo_pkg::ST_OUT: begin
                if (out_free) begin
                    out_data_next = {jerk_reg, anew_reg, vnew_reg};
                    m_tvalid_next = 1'b1;
                    speed_next    = vnew_reg;
                    accel_next    = anew_reg;
                    acc_next      = '0;
                    state_next    = wodo_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wodo_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= wodo_pkg::ST_IDLE;
            last_left_reg  <= '0;
            last_right_reg <= '0;
            acc_reg        <= '0;
            speed_reg      <= '0;
            accel_reg      <= '0;
            mpc_reg        <= wodo_pkg::MPC_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            last_left_reg  <= last_left_next;
            last_right_reg <= last_right_next;
            acc_reg        <= acc_next;
            speed_reg      <= speed_next;
            accel_reg      <= accel_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_wr_en) begin
                mpc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        wend_reg     <= wend_next;
        q_reg        <= q_next;
        vnew_reg     <= vnew_next;
        anew_reg     <= anew_next;
        jerk_reg     <= jerk_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_mul_done_in_mul_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == wodo_pkg::ST_MUL_DIST || state_reg == wodo_pkg::ST_MUL_VEL))
        else $error("Multiplier finished outside a multiply state.");

    a_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wodo_pkg::ST_OUT && m_tvalid_reg && !m_axis_tready)
        |=> (state_reg == wodo_pkg::ST_OUT))
        else $error("Result overwrote a transfer still pending.");

    a_accel_matches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wodo_pkg::ST_OUT && out_free)
        |=> (accel_reg == m_axis_tdata[2*OW-1:OW] && m_axis_tvalid))
        else $error("Stored acceleration differs from the value sent.");

    a_accept_starts_multiply: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == wodo_pkg::ST_MUL_DIST))
        else $error("Accepted transfer did not start the distance multiply.");

endmodule
